### rtl/slex_pkg.sv
`timescale 1ns / 1ps
package slex_pkg;

  localparam int unsigned PosBits = 16;
  localparam int unsigned KwMax   = 6;
  localparam int unsigned NumRes  = 3;

  localparam logic [PosBits-1:0] PosMax = '1;
  localparam logic [15:0]        LineMax = 16'hFFFF;

  localparam logic [5:0] K_LPAREN = 6'd0;
  localparam logic [5:0] K_RPAREN = 6'd1;
  localparam logic [5:0] K_LBRACE = 6'd2;
  localparam logic [5:0] K_RBRACE = 6'd3;
  localparam logic [5:0] K_COMMA  = 6'd4;
  localparam logic [5:0] K_DOT    = 6'd5;
  localparam logic [5:0] K_MINUS  = 6'd6;
  localparam logic [5:0] K_PLUS   = 6'd7;
  localparam logic [5:0] K_SEMI   = 6'd8;
  localparam logic [5:0] K_SLASH  = 6'd9;
  localparam logic [5:0] K_STAR   = 6'd10;
  localparam logic [5:0] K_BANG   = 6'd11;
  localparam logic [5:0] K_EQUAL  = 6'd13;
  localparam logic [5:0] K_GREATER = 6'd15;
  localparam logic [5:0] K_LESS   = 6'd17;
  localparam logic [5:0] K_STRING = 6'd19;
  localparam logic [5:0] K_NUMBER = 6'd20;
  localparam logic [5:0] K_IDENT  = 6'd21;
  localparam logic [5:0] K_AND    = 6'd22;
  localparam logic [5:0] K_CLASS  = 6'd23;
  localparam logic [5:0] K_ELSE   = 6'd24;
  localparam logic [5:0] K_FALSE  = 6'd25;
  localparam logic [5:0] K_FOR    = 6'd26;
  localparam logic [5:0] K_FUN    = 6'd27;
  localparam logic [5:0] K_IF     = 6'd28;
  localparam logic [5:0] K_NIL    = 6'd29;
  localparam logic [5:0] K_OR     = 6'd30;
  localparam logic [5:0] K_PRINT  = 6'd31;
  localparam logic [5:0] K_RETURN = 6'd32;
  localparam logic [5:0] K_SUPER  = 6'd33;
  localparam logic [5:0] K_THIS   = 6'd34;
  localparam logic [5:0] K_TRUE   = 6'd35;
  localparam logic [5:0] K_VAR    = 6'd36;
  localparam logic [5:0] K_WHILE  = 6'd37;
  localparam logic [5:0] K_ERROR  = 6'd38;
  localparam logic [5:0] K_END    = 6'd39;

  localparam logic [1:0] E_NONE    = 2'd0;
  localparam logic [1:0] E_UNKNOWN = 2'd1;
  localparam logic [1:0] E_UNTERM  = 2'd2;

  typedef enum logic [3:0] {
    M_IDLE, M_SLASH, M_COMMENT, M_BANG, M_EQUAL, M_GREATER, M_LESS,
    M_STRING, M_NUMBER, M_NUMDOT, M_FRACTION, M_WORD
  } mode_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_source;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic [1:0]  error_kind;
    logic        last_of_run;
  } out_item_t;

  function automatic logic [15:0] clamp16(input logic [PosBits-1:0] v);
    if (PosBits > 16 && v > PosBits'(16'hFFFF)) return 16'hFFFF;
    return 16'(v);
  endfunction

  function automatic logic [PosBits-1:0] span(input logic [PosBits-1:0] from,
                                              input logic [PosBits-1:0] to);
    return (to >= from) ? to - from : '0;
  endfunction

  // plus one, held at the top of the position range
  function automatic logic [PosBits-1:0] inc_sat(input logic [PosBits-1:0] v);
    return (v == PosMax) ? v : v + PosBits'(1);
  endfunction

  function automatic out_item_t mk_tok(input logic [5:0] kind,
                                       input logic [PosBits-1:0] start,
                                       input logic [PosBits-1:0] len,
                                       input logic [15:0] line,
                                       input logic [1:0] err);
    out_item_t t;
    t.token_kind   = kind;
    t.start_offset = clamp16(start);
    t.token_length = clamp16(len);
    t.line_number  = line;
    t.error_kind   = err;
    t.last_of_run  = 1'b0;
    return t;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // letters past the word length read as zero
  function automatic logic [5:0] keyword_kind(input logic [KwMax-1:0][7:0] wbuf,
                                              input logic [2:0] wlen);
    logic [47:0] w;
    logic [5:0]  k;
    w = '0;
    for (int j = 0; j < KwMax; j++) begin
      if (3'(j) < wlen) w[47-8*j -: 8] = wbuf[j];
    end
    unique case ({wlen, w})
      {3'd3, "and",    24'd0}: k = K_AND;
      {3'd5, "class",   8'd0}: k = K_CLASS;
      {3'd4, "else",   16'd0}: k = K_ELSE;
      {3'd5, "false",   8'd0}: k = K_FALSE;
      {3'd3, "for",    24'd0}: k = K_FOR;
      {3'd3, "fun",    24'd0}: k = K_FUN;
      {3'd2, "if",     32'd0}: k = K_IF;
      {3'd3, "nil",    24'd0}: k = K_NIL;
      {3'd2, "or",     32'd0}: k = K_OR;
      {3'd5, "print",   8'd0}: k = K_PRINT;
      {3'd6, "return"       }: k = K_RETURN;
      {3'd5, "super",   8'd0}: k = K_SUPER;
      {3'd4, "this",   16'd0}: k = K_THIS;
      {3'd4, "true",   16'd0}: k = K_TRUE;
      {3'd3, "var",    24'd0}: k = K_VAR;
      {3'd5, "while",   8'd0}: k = K_WHILE;
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

endpackage

### rtl/script_lexer_core.sv
`timescale 1ns / 1ps
// Streaming source scanner. One item (a source byte or the end marker) is taken
// per cycle while in_stall is low; it yields zero to three tokens, held in a
// three-slot result register and handed out one per cycle while out_stall is
// low. An item that yields no tokens does not stall the input; while tokens are
// pending, in_stall holds off the next item. The next item is taken in the same
// cycle as the last token of the previous one.
// cfg_data sets the first line number and restarts line counting.
module script_lexer_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  slex_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output slex_pkg::out_item_t   out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [15:0]           cfg_data
);

  localparam int unsigned PB = slex_pkg::PosBits;

  slex_pkg::mode_t mode_r, mode_nxt;
  logic [PB-1:0]   pos_r, pos_nxt;
  logic [PB-1:0]   tstart_r, tstart_nxt;
  logic [15:0]     line_r, line_nxt;
  logic [slex_pkg::KwMax-1:0][7:0] wbuf_r, wbuf_nxt;
  logic [2:0]      wlen_r, wlen_nxt;

  slex_pkg::out_item_t [slex_pkg::NumRes-1:0] res_r, res_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] idx_r;
  logic       busy_r;

  logic in_fire, out_fire, last_take;
  logic [7:0] c;
  logic [PB-1:0] p, d;
  logic again;
  logic [1:0] n;

  assign cfg_ready = 1'b1;
  assign out_valid = busy_r;
  assign out_data  = res_r[idx_r];
  assign out_fire  = busy_r && !out_stall;
  assign last_take = out_fire && (idx_r == cnt_r - 2'd1);
  assign in_stall  = busy_r && !last_take;
  assign in_fire   = in_valid && !in_stall;

  assign c = in_data.text_byte;
  assign p = pos_r;
  assign d = (pos_r != '0) ? pos_r - PB'(1) : '0;

  always_comb begin
    mode_nxt   = mode_r;
    pos_nxt    = pos_r;
    tstart_nxt = tstart_r;
    line_nxt   = line_r;
    wbuf_nxt   = wbuf_r;
    wlen_nxt   = wlen_r;
    res_nxt    = '0;
    n          = 2'd0;
    again      = 1'b0;
    if (in_data.end_of_source) begin
      unique case (mode_r)
        slex_pkg::M_SLASH: begin
          res_nxt[n] = slex_pkg::mk_tok(slex_pkg::K_SLASH, tstart_r, PB'(1), line_r,
                                        slex_pkg::E_NONE);
          n = n + 2'd1;
        end
        slex_pkg::M_BANG, slex_pkg::M_EQUAL, slex_pkg::M_GREATER, slex_pkg::M_LESS: begin
          res_nxt[n] = slex_pkg::mk_tok(slex_pkg::K_BANG + 6'(2 * (mode_r - slex_pkg::M_BANG)),
                                        tstart_r, PB'(1), line_r, slex_pkg::E_NONE);
          n = n + 2'd1;
        end
        slex_pkg::M_STRING: begin
          res_nxt[n] = slex_pkg::mk_tok(slex_pkg::K_ERROR, tstart_r,
                                        slex_pkg::span(tstart_r, p), line_r,
                                        slex_pkg::E_UNTERM);
          n = n + 2'd1;
        end
        slex_pkg::M_NUMBER, slex_pkg::M_FRACTION: begin
          res_nxt[n] = slex_pkg::mk_tok(slex_pkg::K_NUMBER, tstart_r,
                                        slex_pkg::span(tstart_r, p), line_r,
                                        slex_pkg::E_NONE);
          n = n + 2'd1;
        end
        slex_pkg::M_NUMDOT: begin
          res_nxt[0] = slex_pkg::mk_tok(slex_pkg::K_NUMBER, tstart_r,
                                        slex_pkg::span(tstart_r, d), line_r,
                                        slex_pkg::E_NONE);
          res_nxt[1] = slex_pkg::mk_tok(slex_pkg::K_DOT, d, PB'(1), line_r,
                                        slex_pkg::E_NONE);
          n = 2'd2;
        end
        slex_pkg::M_WORD: begin
          res_nxt[n] = slex_pkg::mk_tok(slex_pkg::keyword_kind(wbuf_r, wlen_r), tstart_r,
                                        slex_pkg::span(tstart_r, p), line_r,
                                        slex_pkg::E_NONE);
          n = n + 2'd1;
        end
        default: ;
      endcase
      res_nxt[n] = slex_pkg::mk_tok(slex_pkg::K_END, p, '0, line_r, slex_pkg::E_NONE);
      n = n + 2'd1;
      mode_nxt = slex_pkg::M_IDLE;
    end else begin
      if (pos_r != slex_pkg::PosMax) pos_nxt = pos_r + PB'(1);
      unique case (mode_r)
        slex_pkg::M_SLASH: begin
          if (c == "/") mode_nxt = slex_pkg::M_COMMENT;
          else begin
            res_nxt[0] = slex_pkg::mk_tok(slex_pkg::K_SLASH, tstart_r, PB'(1), line_r,
                                          slex_pkg::E_NONE);
            n = 2'd1;
            again = 1'b1;
          end
        end
        slex_pkg::M_COMMENT: begin
          if (c == 8'h0A) begin
            if (line_r != slex_pkg::LineMax) line_nxt = line_r + 16'd1;
            mode_nxt = slex_pkg::M_IDLE;
          end
        end
        slex_pkg::M_BANG, slex_pkg::M_EQUAL, slex_pkg::M_GREATER, slex_pkg::M_LESS: begin
          if (c == "=") begin
            // length runs through this byte, held at the top of the range
            res_nxt[0] = slex_pkg::mk_tok(
              slex_pkg::K_BANG + 6'(2 * (mode_r - slex_pkg::M_BANG)) + 6'd1, tstart_r,
              slex_pkg::inc_sat(slex_pkg::span(tstart_r, p)), line_r, slex_pkg::E_NONE);
            n = 2'd1;
            mode_nxt = slex_pkg::M_IDLE;
          end else begin
            res_nxt[0] = slex_pkg::mk_tok(
              slex_pkg::K_BANG + 6'(2 * (mode_r - slex_pkg::M_BANG)), tstart_r, PB'(1),
              line_r, slex_pkg::E_NONE);
            n = 2'd1;
            again = 1'b1;
          end
        end
        slex_pkg::M_STRING: begin
          if (c == "\"") begin
            res_nxt[0] = slex_pkg::mk_tok(slex_pkg::K_STRING, slex_pkg::inc_sat(tstart_r),
                                          slex_pkg::span(slex_pkg::inc_sat(tstart_r), p),
                                          line_r, slex_pkg::E_NONE);
            n = 2'd1;
            mode_nxt = slex_pkg::M_IDLE;
          end
        end
        slex_pkg::M_NUMBER: begin
          if (c == ".") mode_nxt = slex_pkg::M_NUMDOT;
          else if (!slex_pkg::is_digit(c)) begin
            res_nxt[0] = slex_pkg::mk_tok(slex_pkg::K_NUMBER, tstart_r,
                                          slex_pkg::span(tstart_r, p), line_r,
                                          slex_pkg::E_NONE);
            n = 2'd1;
            again = 1'b1;
          end
        end
        slex_pkg::M_NUMDOT: begin
          if (slex_pkg::is_digit(c)) mode_nxt = slex_pkg::M_FRACTION;
          else begin
            res_nxt[0] = slex_pkg::mk_tok(slex_pkg::K_NUMBER, tstart_r,
                                          slex_pkg::span(tstart_r, d), line_r,
                                          slex_pkg::E_NONE);
            res_nxt[1] = slex_pkg::mk_tok(slex_pkg::K_DOT, d, PB'(1), line_r,
                                          slex_pkg::E_NONE);
            n = 2'd2;
            again = 1'b1;
          end
        end
        slex_pkg::M_FRACTION: begin
          if (!slex_pkg::is_digit(c)) begin
            res_nxt[0] = slex_pkg::mk_tok(slex_pkg::K_NUMBER, tstart_r,
                                          slex_pkg::span(tstart_r, p), line_r,
                                          slex_pkg::E_NONE);
            n = 2'd1;
            again = 1'b1;
          end
        end
        slex_pkg::M_WORD: begin
          if (slex_pkg::is_letter(c) || slex_pkg::is_digit(c)) begin
            if (wlen_r < 3'(slex_pkg::KwMax)) begin
              wbuf_nxt[wlen_r[$clog2(slex_pkg::KwMax)-1:0]] = c;
              wlen_nxt = wlen_r + 3'd1;
            end else begin
              wlen_nxt = 3'(slex_pkg::KwMax + 1);
            end
          end else begin
            res_nxt[0] = slex_pkg::mk_tok(slex_pkg::keyword_kind(wbuf_r, wlen_r), tstart_r,
                                          slex_pkg::span(tstart_r, p), line_r,
                                          slex_pkg::E_NONE);
            n = 2'd1;
            again = 1'b1;
          end
        end
        default: again = 1'b1;
      endcase

      // start of a new token with this byte
      if (again) begin
        tstart_nxt = p;
        mode_nxt   = slex_pkg::M_IDLE;
        priority case (1'b1)
          c == "(": res_nxt[n] = slex_pkg::mk_tok(slex_pkg::K_LPAREN, p, PB'(1), line_r,
                                                  slex_pkg::E_NONE);
          c == ")": res_nxt[n] = slex_pkg::mk_tok(slex_pkg::K_RPAREN, p, PB'(1), line_r,
                                                  slex_pkg::E_NONE);
          c == "{": res_nxt[n] = slex_pkg::mk_tok(slex_pkg::K_LBRACE, p, PB'(1), line_r,
                                                  slex_pkg::E_NONE);
          c == "}": res_nxt[n] = slex_pkg::mk_tok(slex_pkg::K_RBRACE, p, PB'(1), line_r,
                                                  slex_pkg::E_NONE);
          c == ",": res_nxt[n] = slex_pkg::mk_tok(slex_pkg::K_COMMA, p, PB'(1), line_r,
                                                  slex_pkg::E_NONE);
          c == ".": res_nxt[n] = slex_pkg::mk_tok(slex_pkg::K_DOT, p, PB'(1), line_r,
                                                  slex_pkg::E_NONE);
          c == "-": res_nxt[n] = slex_pkg::mk_tok(slex_pkg::K_MINUS, p, PB'(1), line_r,
                                                  slex_pkg::E_NONE);
          c == "+": res_nxt[n] = slex_pkg::mk_tok(slex_pkg::K_PLUS, p, PB'(1), line_r,
                                                  slex_pkg::E_NONE);
          c == ";": res_nxt[n] = slex_pkg::mk_tok(slex_pkg::K_SEMI, p, PB'(1), line_r,
                                                  slex_pkg::E_NONE);
          c == "*": res_nxt[n] = slex_pkg::mk_tok(slex_pkg::K_STAR, p, PB'(1), line_r,
                                                  slex_pkg::E_NONE);
          default: ;
        endcase
        priority case (1'b1)
          c == "(" || c == ")" || c == "{" || c == "}" || c == "," || c == "." ||
          c == "-" || c == "+" || c == ";" || c == "*": n = n + 2'd1;
          c == "/": mode_nxt = slex_pkg::M_SLASH;
          c == "!": mode_nxt = slex_pkg::M_BANG;
          c == "=": mode_nxt = slex_pkg::M_EQUAL;
          c == ">": mode_nxt = slex_pkg::M_GREATER;
          c == "<": mode_nxt = slex_pkg::M_LESS;
          c == " " || c == 8'h09 || c == 8'h0D: ;
          c == 8'h0A: begin
            if (line_r != slex_pkg::LineMax) line_nxt = line_r + 16'd1;
          end
          c == "\"": mode_nxt = slex_pkg::M_STRING;
          slex_pkg::is_digit(c): mode_nxt = slex_pkg::M_NUMBER;
          slex_pkg::is_letter(c): begin
            mode_nxt    = slex_pkg::M_WORD;
            wbuf_nxt[0] = c;
            wlen_nxt    = 3'd1;
          end
          default: begin
            res_nxt[n] = slex_pkg::mk_tok(slex_pkg::K_ERROR, p, PB'(1), line_r,
                                          slex_pkg::E_UNKNOWN);
            n = n + 2'd1;
          end
        endcase
      end
    end
    if (n != 2'd0) res_nxt[n - 2'd1].last_of_run = 1'b1;
    cnt_nxt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= slex_pkg::M_IDLE;
      pos_r    <= '0;
      tstart_r <= '0;
      line_r   <= 16'd1;
      wlen_r   <= 3'd0;
      busy_r   <= 1'b0;
      cnt_r    <= 2'd0;
      idx_r    <= 2'd0;
    end else begin
      if (in_fire) begin
        mode_r   <= mode_nxt;
        pos_r    <= pos_nxt;
        tstart_r <= tstart_nxt;
        line_r   <= line_nxt;
        wlen_r   <= wlen_nxt;
        busy_r   <= cnt_nxt != 2'd0;
        cnt_r    <= cnt_nxt;
        idx_r    <= 2'd0;
      end else if (out_fire) begin
        if (last_take) busy_r <= 1'b0;
        else idx_r <= idx_r + 2'd1;
      end
      if (cfg_valid && cfg_ready) line_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      wbuf_r <= wbuf_nxt;
      res_r  <= res_nxt;
    end
  end

  // result slots only ever hold one to three tokens
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != 2'd0 && idx_r < cnt_r))
    else $error("result slot index out of range");

  // the end marker always produces at least the end token
  a_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.end_of_source |=> busy_r)
    else $error("end marker gave no token");

  // a new item is only taken once the previous tokens are gone
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (!busy_r || last_take))
    else $error("item taken over pending tokens");

  // last_of_run is on the final slot of a run
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_of_run == (idx_r == cnt_r - 2'd1)))
    else $error("last_of_run misplaced");

endmodule
